// ===== design/sqhdf_pkg.sv =====
package sqhdf_pkg;

	localparam int TABLE_ENTRIES  = 16;
	localparam int SEQUENCE_CYCLE = 60000;

	localparam int ADDR_W   = 32;
	localparam int SEQ_W    = 16;
	localparam int TIME_W   = 32;
	localparam int PURGE_W  = 5;
	localparam int IDX_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int MEM_W    = ADDR_W + SEQ_W + TIME_W;
	localparam int S_DATA_W = ((ADDR_W + SEQ_W + TIME_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((2 + PURGE_W + 7) / 8) * 8;

	localparam logic [TIME_W-1:0] HOLD_TIME_RESET = TIME_W'(30000);
	localparam logic [SEQ_W-1:0]  SEQ_CYCLE       = SEQ_W'(SEQUENCE_CYCLE);

	localparam logic OP_MESSAGE = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	function automatic logic stored_is_newer(input logic [SEQ_W-1:0] s, input logic [SEQ_W-1:0] n);
		logic [SEQ_W-1:0] d_sn;
		logic [SEQ_W-1:0] d_ns;
		d_sn = s - n;
		d_ns = n - s;
		return ((s > n) && (d_sn < SEQ_CYCLE)) || ((s < n) && (d_ns > SEQ_CYCLE));
	endfunction

endpackage

// ===== design/seq_history_duplicate_filter_core.sv =====
// Channel   Dir  Payload
// s_*       in   tuser: opcode; tdata: originator_address, sequence_number, current_time
// m_*       out  tdata: discard, table_full, purged_count
// cfg_*     in   cfg_wdata: hold_time
//
// Each item is scanned in ST_SCAN, which reads one table entry per cycle from the
// single-port entry memory; ST_DRAIN drains the last read and ST_FINISH writes back.
// A new item is accepted while the previous result waits on m_tvalid.
// The write-back stalls only while the output register still holds an untaken result.
// arst_n clears valid bits, control state and hold_time (30000); the entry memory
// itself has no reset and is never read through an invalid entry.
module seq_history_duplicate_filter_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [31:0] originator_address, [47:32] sequence_number, [79:48] current_time
	input  logic [sqhdf_pkg::S_DATA_W-1:0] s_tdata,
	// [0] opcode
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] discard, [1] table_full, [6:2] purged_count, [7] zero
	output logic [sqhdf_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                           cfg_we,
	input  logic [sqhdf_pkg::TIME_W-1:0]   cfg_wdata
);
	import sqhdf_pkg::*;

	state_t state_q, state_d;

	logic [TIME_W-1:0]        hold_time_q;
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic              op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [TIME_W-1:0] now_q;

	logic [IDX_W-1:0] rd_idx_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic [MEM_W-1:0] rdata_s1;

	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [SEQ_W-1:0] hit_seq_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [PURGE_W-1:0] purged_q;

	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	logic [MEM_W-1:0] mem [TABLE_ENTRIES];

	logic              accept;
	logic              finish;
	logic              last_rd;
	logic [ADDR_W-1:0] e_addr;
	logic [SEQ_W-1:0]  e_seq;
	logic [TIME_W-1:0] e_expiry;
	logic [TIME_W-1:0] new_expiry;
	logic              newer;
	logic              res_discard;
	logic              res_full;
	logic              do_update;
	logic              do_insert;

	assign e_addr     = rdata_s1[ADDR_W-1:0];
	assign e_seq      = rdata_s1[ADDR_W +: SEQ_W];
	assign e_expiry   = rdata_s1[ADDR_W+SEQ_W +: TIME_W];
	assign new_expiry = now_q + hold_time_q;
	assign newer      = stored_is_newer(hit_seq_q, seq_q);
	assign last_rd    = (rd_idx_q == IDX_W'(TABLE_ENTRIES - 1));

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		finish   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_rd) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_comb begin
		res_discard = 1'b0;
		res_full    = 1'b0;
		do_update   = 1'b0;
		do_insert   = 1'b0;
		if (op_q == OP_MESSAGE) begin
			if (hit_q && newer) begin
				res_discard = 1'b1;
			end else if (hit_q) begin
				do_update = (hit_seq_q != seq_q);
			end else if (free_q) begin
				do_insert = 1'b1;
			end else begin
				res_full = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_time_q <= HOLD_TIME_RESET;
		end else if (cfg_we) begin
			hold_time_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= s_tuser;
			addr_q <= s_tdata[ADDR_W-1:0];
			seq_q  <= s_tdata[ADDR_W +: SEQ_W];
			now_q  <= s_tdata[ADDR_W+SEQ_W +: TIME_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			cmp_vld_s1 <= (state_q == ST_SCAN);
			cmp_idx_s1 <= rd_idx_q;
			if (accept) begin
				rd_idx_q <= '0;
			end else if (state_q == ST_SCAN) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish && do_update) begin
			mem[hit_idx_q] <= {new_expiry, seq_q, addr_q};
		end else if (finish && do_insert) begin
			mem[free_idx_q] <= {new_expiry, seq_q, addr_q};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			rdata_s1 <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			hit_seq_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			purged_q   <= '0;
		end else if (accept) begin
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			purged_q <= '0;
		end else if (cmp_vld_s1) begin
			if (op_q == OP_TICK) begin
				if (valid_q[cmp_idx_s1] && (e_expiry < now_q)) begin
					valid_q[cmp_idx_s1] <= 1'b0;
					if (purged_q != '1) begin
						purged_q <= purged_q + PURGE_W'(1);
					end
				end
			end else if (valid_q[cmp_idx_s1]) begin
				if (!hit_q && (e_addr == addr_q)) begin
					hit_q     <= 1'b1;
					hit_idx_q <= cmp_idx_s1;
					hit_seq_q <= e_seq;
				end
			end else if (!free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= cmp_idx_s1;
			end
		end else if (finish && do_insert) begin
			valid_q[free_idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_tdata_q <= M_DATA_W'({purged_q, res_full, res_discard});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
